// ===== rtl/mm256_pkg.sv =====
// Package for the 256-bit Montgomery multiplier: widths, pipeline payload types
// and the partial-product helpers used by the row pipeline.
// Depends on nothing.
package mm256_pkg;

  localparam int unsigned LIMB_W = 64;
  localparam int unsigned OPD_W  = 256;
  localparam int unsigned ACC_W  = 384;
  localparam int unsigned PSUM_W = 320;

  typedef enum logic [2:0] {
    CFG_MOD0 = 3'd0,
    CFG_MOD1 = 3'd1,
    CFG_MOD2 = 3'd2,
    CFG_MOD3 = 3'd3,
    CFG_NINV = 3'd4
  } cfg_idx_e;

  // Sixteen 32x32 partial products of a 256x64 multiply, entry 2*j+k holds
  // digit j of the wide operand times digit k of the limb.
  typedef logic [15:0][63:0] pp_t;
  typedef logic [1:0][PSUM_W-1:0] psum_t;

  typedef struct packed {
    logic [OPD_W-1:0] a;
    logic [OPD_W-1:0] b;
    logic [ACC_W-1:0] acc;
  } row_t;

  function automatic pp_t mul_parts(input logic [OPD_W-1:0] x, input logic [LIMB_W-1:0] y);
    pp_t         p;
    logic [31:0] xd;
    logic [31:0] yd;
    for (int j = 0; j < 8; j++) begin
      for (int k = 0; k < 2; k++) begin
        xd = x[32*j +: 32];
        yd = y[32*k +: 32];
        p[2*j+k] = 64'(xd) * 64'(yd);
      end
    end
    return p;
  endfunction

  // Partial products of equal digit parity do not overlap, so they pack into
  // four vectors; those are added in two independent pairs.
  function automatic psum_t pair_sums(input pp_t p);
    psum_t      r;
    logic [255:0] c00, c01, c10, c11;
    c00 = {p[12], p[8], p[4], p[0]};
    c01 = {p[14], p[10], p[6], p[2]};
    c10 = {p[13], p[9], p[5], p[1]};
    c11 = {p[15], p[11], p[7], p[3]};
    r[0] = {64'b0, c00} + {32'b0, c01, 32'b0};
    r[1] = {32'b0, c10, 32'b0} + {c11, 64'b0};
    return r;
  endfunction

endpackage

// ===== rtl/mm256_row.sv =====
// One CIOS row of the Montgomery multiplier as an eight-stage pipeline:
// add a*b_i, form mu, add mu*m and shift down one limb.
// Depends on mm256_pkg.
module mm256_row (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  mm256_pkg::row_t                 data_i,
  input  logic [7:0]                      en_i,
  input  logic [mm256_pkg::OPD_W-1:0]     modulus_i,
  input  logic [mm256_pkg::LIMB_W-1:0]    ninv_i,
  output logic [7:0]                      valid_o,
  output mm256_pkg::row_t                 data_o
);

  logic [7:0] v_q;

  mm256_pkg::row_t  d1_q, d2_q, d3_q, d4_q, d5_q, d6_q, d7_q, d8_q;
  mm256_pkg::pp_t   pp1_q, pp6_q;
  mm256_pkg::psum_t ps2_q, ps7_q;
  logic [63:0]      ll4_q;
  logic [31:0]      lh4_q, hl4_q;
  logic [63:0]      mu5_q;

  logic [63:0]      lh_full, hl_full;
  logic [mm256_pkg::ACC_W-1:0] acc3_d, sum8;

  always_comb begin
    lh_full = 64'(d3_q.acc[31:0]) * 64'(ninv_i[63:32]);
    hl_full = 64'(d3_q.acc[63:32]) * 64'(ninv_i[31:0]);
    acc3_d  = d2_q.acc + {64'b0, ps2_q[0]} + {64'b0, ps2_q[1]};
    sum8    = d7_q.acc + {64'b0, ps7_q[0]} + {64'b0, ps7_q[1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en_i[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < 8; k++) begin
        if (en_i[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      d1_q  <= data_i;
      pp1_q <= mm256_pkg::mul_parts(data_i.a, data_i.b[63:0]);
    end
    if (en_i[1]) begin
      d2_q  <= d1_q;
      ps2_q <= mm256_pkg::pair_sums(pp1_q);
    end
    if (en_i[2]) begin
      d3_q.a   <= d2_q.a;
      d3_q.b   <= d2_q.b;
      d3_q.acc <= acc3_d;
    end
    if (en_i[3]) begin
      d4_q  <= d3_q;
      ll4_q <= 64'(d3_q.acc[31:0]) * 64'(ninv_i[31:0]);
      lh4_q <= lh_full[31:0];
      hl4_q <= hl_full[31:0];
    end
    if (en_i[4]) begin
      d5_q  <= d4_q;
      mu5_q <= ll4_q + {lh4_q + hl4_q, 32'b0};
    end
    if (en_i[5]) begin
      d6_q  <= d5_q;
      pp6_q <= mm256_pkg::mul_parts(modulus_i, mu5_q);
    end
    if (en_i[6]) begin
      d7_q  <= d6_q;
      ps7_q <= mm256_pkg::pair_sums(pp6_q);
    end
    if (en_i[7]) begin
      // The low limb is dropped and the next limb of b moves into place.
      d8_q.a   <= d7_q.a;
      d8_q.b   <= {64'b0, d7_q.b[255:64]};
      d8_q.acc <= {64'b0, sum8[383:64]};
    end
  end

  assign valid_o = v_q;
  assign data_o  = d8_q;

endmodule

// ===== rtl/montgomery_multiply_256.sv =====
// Pipelined 256-bit Montgomery multiplier, product = a*b*2^-256 mod m (CIOS).
// Four rows of eight stages, plus the final subtraction stage, which is also
// the output register, lie between input transfer and result.
// Throughput: one transfer per cycle; every stage stalls on its own, so bubbles
// are squeezed out while a result waits. Reset clears all valid bits and sets
// the modulus and inverse registers to zero. Built on mm256_pkg and mm256_row.
module montgomery_multiply_256 (
  input  logic          clk_i,
  input  logic          rst_ni,
  // Configuration write port.
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [63:0]   cfg_data_i,
  // Operand stream.
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // a_limb0, a_limb1, a_limb2, a_limb3, b_limb0, b_limb1, b_limb2, b_limb3
  input  logic [511:0]  s_axis_tdata,
  // Result stream.
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // product_limb0, product_limb1, product_limb2, product_limb3
  output logic [255:0]  m_axis_tdata
);

  localparam int unsigned NSTG = 32;

  // Configuration registers; written only while the pipeline is empty (a rule for the user, not enforced by the block).
  logic [3:0][63:0] mod_q;
  logic [63:0]      ninv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q  <= '0;
      ninv_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mm256_pkg::CFG_MOD0: mod_q[0] <= cfg_data_i;
        mm256_pkg::CFG_MOD1: mod_q[1] <= cfg_data_i;
        mm256_pkg::CFG_MOD2: mod_q[2] <= cfg_data_i;
        mm256_pkg::CFG_MOD3: mod_q[3] <= cfg_data_i;
        mm256_pkg::CFG_NINV: ninv_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage enables: a stage loads when it is empty or when the stage after it
  // moves on. The last entry is the output register.
  logic [NSTG:0]   vld;
  logic [NSTG:0]   en;
  logic            out_v_q;
  logic [255:0]    out_q;

  always_comb begin
    en[NSTG] = !out_v_q || m_axis_tready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[0];
  assign vld[NSTG]     = out_v_q;

  // Four rows chained; row r consumes limb r of b.
  mm256_pkg::row_t rd [0:4];
  logic            rv [0:4];

  // Fields a, b and a cleared accumulator, from the top bit down.
  assign rd[0] = {s_axis_tdata[255:0], s_axis_tdata[511:256], 384'b0};
  assign rv[0] = s_axis_tvalid;

  for (genvar r = 0; r < 4; r++) begin : g_row
    mm256_row u_row (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .valid_i   (rv[r]),
      .data_i    (rd[r]),
      .en_i      (en[8*r +: 8]),
      .modulus_i (mod_q),
      .ninv_i    (ninv_q),
      .valid_o   (vld[8*r +: 8]),
      .data_o    (rd[r+1])
    );
    assign rv[r+1] = vld[8*r+7];
  end

  // Final conditional subtraction: take acc - m when the limb above the low
  // 256 bits is nonzero or when the subtraction does not borrow.
  logic [256:0] diff;
  logic         take;

  always_comb begin
    diff = {1'b0, rd[4].acc[255:0]} - {1'b0, mod_q};
    take = (rd[4].acc[319:256] != 64'b0) || !diff[256];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en[NSTG]) begin
      out_v_q <= vld[NSTG-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NSTG]) begin
      out_q <= take ? diff[255:0] : rd[4].acc[255:0];
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

`ifndef ASSERT_OFF
  // Input back-pressure only arises when every stage holds an item.
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (&vld))
    else $error("input stalled while the pipeline has an empty stage");

  // A taken result with nothing behind it leaves the output empty.
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !vld[NSTG-1]) |=> !m_axis_tvalid)
    else $error("result repeated after transfer");
`endif

endmodule
